// ===== hdl/sss_pkg.sv =====
// Shared constants, widths and command codes of the sorted sequence store.
package sss_pkg;

  // Store size and derived widths
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int COUNT_W = 5;
  localparam int VALUE_W = 32;

  // Stream widths
  localparam int S_TDATA_W = 32;  // value_in
  localparam int S_TUSER_W = 2;   // cmd
  localparam int M_TDATA_W = 40;  // value_out, count_out, zero padding
  localparam int M_TUSER_W = 2;   // found, full_error

  // Command codes
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_DUMP    = 2'd3
  } cmd_t;

endpackage

// ===== hdl/sorted_sequence_store.sv =====
// Sorted sequence store: ordered store of signed values with insert, remove, reverse and dump.
//
// Usage: one command transaction arrives on the s_ channel (s_tuser = cmd, s_tdata = value).
// Insert places the value after every leading entry less than or equal to it; a full store
// refuses it with full_error. Remove deletes the first equal entry and returns it with found.
// Reverse flips the held order. Dump returns every entry in order on the m_ channel, with
// m_tlast on the final one; an empty store gives a single zero result with m_tlast set.
// Every other command gives exactly one result, m_tlast set.
// Insert and remove make one read/compare pass over the single RAM, with the shift written
// back behind the read; reverse swaps one pair at a time, bound by the one read and one
// write port; dump reads and sends the entries one at a time. s_tready is high only while
// the sequencer is idle, one command at a time.
// Results sit in one output register; a stalled receiver holds the sequencer at its result
// step, and a new command may be taken while the last result still waits there.
// Reset empties the store at once (count to zero, no clearing pass) and drops any pending
// result.
module sorted_sequence_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sss_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] value_in
  input  logic [sss_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] cmd
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sss_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] value_out, [36:32] count_out, pad
  output logic [sss_pkg::M_TUSER_W-1:0] m_tuser,   // [0] found, [1] full_error
  output logic                          m_tlast
);

  import sss_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_SCAN     = 10'b00_0000_0010,
    ST_SCAN_END = 10'b00_0000_0100,
    ST_REV_A    = 10'b00_0000_1000,
    ST_REV_B    = 10'b00_0001_0000,
    ST_REV_C    = 10'b00_0010_0000,
    ST_REV_D    = 10'b00_0100_0000,
    ST_DUMP_RD  = 10'b00_1000_0000,
    ST_DUMP_OUT = 10'b01_0000_0000,
    ST_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t               state;
  cmd_t                 cmd_r;
  logic [VALUE_W-1:0]   value_r;
  logic [VALUE_W-1:0]   carry;
  logic [VALUE_W-1:0]   tmp;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   idx;
  logic                 pend;
  logic                 hit;
  logic                 found_r;
  logic [IDX_W-1:0]     lo;
  logic [IDX_W-1:0]     hi;
  logic [VALUE_W-1:0]   res_value;
  logic                 res_found;
  logic                 res_full;
  logic [VALUE_W-1:0]   out_value;
  logic                 out_found;
  logic                 out_full;
  logic [COUNT_W-1:0]   out_count;
  logic                 out_last;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [VALUE_W-1:0]   wr_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [VALUE_W-1:0]   rd_data;

  logic [IDX_W-1:0]     pos;
  logic [COUNT_W-1:0]   cnt_m1;
  logic                 gt;
  logic                 eq;
  logic                 out_free;
  logic                 emit;
  logic                 rev_more;

  sss_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared compare unit and index arithmetic
  assign gt       = $signed(rd_data) > $signed(value_r);
  assign eq       = rd_data == value_r;
  assign pos      = idx[IDX_W-1:0] - IDX_W'(1);
  assign cnt_m1   = count - COUNT_W'(1);
  assign out_free = !m_tvalid || m_tready;
  assign emit     = out_free && (state == ST_DUMP_OUT || state == ST_FINISH);
  assign rev_more = ({1'b0, lo} + (IDX_W + 1)'(2)) < {1'b0, hi};

  // RAM read address
  always_comb begin
    case (state)
      ST_REV_A: rd_addr = lo;
      ST_REV_B: rd_addr = hi;
      default:  rd_addr = idx[IDX_W-1:0];
    endcase
  end

  // RAM write port: shift behind the scan, tail write, swap halves
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = carry;
    case (state)
      ST_SCAN: begin
        if (pend) begin
          if (cmd_r == CMD_INSERT) begin
            wr_en   = hit || gt;
            wr_addr = pos;
            wr_data = carry;
          end else begin
            wr_en   = found_r;
            wr_addr = pos - IDX_W'(1);
            wr_data = rd_data;
          end
        end
      end
      ST_SCAN_END: begin
        wr_en   = cmd_r == CMD_INSERT;
        wr_addr = count[IDX_W-1:0];
        wr_data = carry;
      end
      ST_REV_C: begin
        wr_en   = 1'b1;
        wr_addr = lo;
        wr_data = rd_data;
      end
      ST_REV_D: begin
        wr_en   = 1'b1;
        wr_addr = hi;
        wr_data = tmp;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // result register: load on a result step, clear once taken
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_r     <= cmd_t'(s_tuser);
            value_r   <= s_tdata;
            carry     <= s_tdata;
            res_value <= '0;
            res_found <= 1'b0;
            res_full  <= 1'b0;
            hit       <= 1'b0;
            found_r   <= 1'b0;
            idx       <= '0;
            pend      <= 1'b0;
            lo        <= '0;
            hi        <= cnt_m1[IDX_W-1:0];
            case (cmd_t'(s_tuser))
              CMD_INSERT: begin
                if (count == COUNT_W'(DEPTH)) begin
                  res_full <= 1'b1;
                  state    <= ST_FINISH;
                end else begin
                  state <= ST_SCAN;
                end
              end
              CMD_REMOVE:  state <= ST_SCAN;
              CMD_REVERSE: state <= (count < COUNT_W'(2)) ? ST_FINISH : ST_REV_A;
              CMD_DUMP:    state <= (count == '0) ? ST_FINISH : ST_DUMP_RD;
              default:     state <= ST_FINISH;
            endcase
          end
        end
        ST_SCAN: begin
          if (idx != count) begin
            idx  <= idx + COUNT_W'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (cmd_r == CMD_INSERT) begin
              // once past the insertion point, every entry moves up one slot
              if (hit || gt) begin
                hit   <= 1'b1;
                carry <= rd_data;
              end
            end else if (!found_r && eq) begin
              found_r <= 1'b1;
            end
          end
          if (idx == count && !pend) begin
            state <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          if (cmd_r == CMD_INSERT) begin
            count <= count + COUNT_W'(1);
          end else if (found_r) begin
            count     <= cnt_m1;
            res_value <= value_r;
            res_found <= 1'b1;
          end
          state <= ST_FINISH;
        end
        ST_REV_A: state <= ST_REV_B;
        ST_REV_B: begin
          tmp   <= rd_data;
          state <= ST_REV_C;
        end
        ST_REV_C: state <= ST_REV_D;
        ST_REV_D: begin
          if (rev_more) begin
            lo    <= lo + IDX_W'(1);
            hi    <= hi - IDX_W'(1);
            state <= ST_REV_A;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_DUMP_RD: state <= ST_DUMP_OUT;
        ST_DUMP_OUT: begin
          if (out_free) begin
            out_value <= rd_data;
            out_found <= 1'b1;
            out_full  <= 1'b0;
            out_count <= count;
            out_last  <= idx == cnt_m1;
            idx       <= idx + COUNT_W'(1);
            state     <= (idx == cnt_m1) ? ST_IDLE : ST_DUMP_RD;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_value <= res_value;
            out_found <= res_found;
            out_full  <= res_full;
            out_count <= count;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output packing
  assign s_tready = state == ST_IDLE;
  assign m_tdata  = {(M_TDATA_W - VALUE_W - COUNT_W)'(0), out_count, out_value};
  assign m_tuser  = {out_full, out_found};
  assign m_tlast  = out_last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("entry count above store depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_full |-> out_count == COUNT_W'(DEPTH) && out_value == '0)
    else $error("full_error without a full store");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_found && out_full))
    else $error("found and full_error together");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_SCAN || state == ST_SCAN_END ||
               state == ST_REV_C || state == ST_REV_D))
    else $error("store written outside an update step");

endmodule

// ===== hdl/sss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
